### design/bpa_pkg.sv
// Package for the bitmap page allocator: request codes, sequencer states and
// search modes. No dependencies.
`timescale 1ns / 1ps

package bpa_pkg;

  typedef enum logic [2:0] {
    REQ_ALLOC_ONE = 3'd0,
    REQ_FREE_ONE  = 3'd1,
    REQ_ALLOC_RUN = 3'd2,
    REQ_FREE_RUN  = 3'd3,
    REQ_MARK_USED = 3'd4
  } req_t;

  typedef enum logic [4:0] {
    S_CLR  = 5'b00001,
    S_IDLE = 5'b00010,
    S_RD   = 5'b00100,
    S_EX   = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  // what the execute cycle does with the word that was read
  typedef enum logic [1:0] {
    M_ONE   = 2'd0,
    M_RUN   = 2'd1,
    M_RANGE = 2'd2
  } mode_t;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned SUB_BITS  = 8;

endpackage

### design/bitmap_page_allocator_core.sv
// Bitmap page allocator top level: free map in one synchronous RAM, word-wise
// read-modify-write sequencer. Depends on bpa_pkg.
`timescale 1ns / 1ps

// channel  direction  handshake        payload
// in       input      in_valid/stall   req_type, page_number, run_length
// out      output     out_valid/stall  start_page, found, range_error
//
// After reset the map is cleared one word a cycle, with in_stall high.
// Each item is accepted in S_IDLE and hands its result over in S_DONE.
// Alloc one: each map word scanned is read (S_RD) and examined (S_EX), up to all MAP_WORDS.
// Alloc run: each word scanned is read, then searched 8 pages a cycle; each word of the run taken is rewritten.
// Free/mark: one read and one write per word touched. One item at a time; in_stall is high while busy.
// A finished result waits in the output register; the core stalls only if it is still full.

module bitmap_page_allocator_core
  import bpa_pkg::*;
#(
  parameter int MAP_WORDS = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [11:0] in_page_number,
  input  logic [12:0] in_run_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_start_page,
  output logic        out_found,
  output logic        out_range_error
);

  localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PW = AW + 5;
  localparam int CW = (AW + 6 > 14) ? AW + 6 : 14;
  localparam logic [CW-1:0] PAGE_COUNT = CW'(MAP_WORDS * 32);
  localparam logic [AW-1:0] LAST_WORD  = AW'(MAP_WORDS - 1);

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] mem_rd_r;
  logic                 mem_we;
  logic [WORD_BITS-1:0] mem_wd;

  state_t        state_r, state_nxt;
  mode_t         mode_r, mode_nxt;
  logic [AW-1:0] word_r, word_nxt;
  logic [1:0]    sub_r, sub_nxt;
  logic [12:0]   run_r, run_nxt;
  logic [12:0]   len_r, len_nxt;
  logic [PW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic          set_r, set_nxt;
  logic [11:0]   res_start_r, res_start_nxt;
  logic          res_found_r, res_found_nxt;
  logic          res_err_r, res_err_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [11:0]   out_start_r;
  logic          out_found_r, out_err_r;

  logic          in_acc;
  logic [CW-1:0] page_c, hi_c;
  logic [4:0]    lo_b, hi_b, first_b;
  logic [31:0]   mask;
  logic [12:0]   run_v;
  logic          hit_v;
  logic [CW-1:0] end_v, start_v;
  logic [7:0]    sub_bits;

  assign in_acc = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[word_r] <= mem_wd;
    end
    mem_rd_r <= mem[word_r];
  end

  // range pass mask
  always_comb begin
    lo_b = (word_r == lo_r[PW-1:5]) ? lo_r[4:0] : 5'd0;
    hi_b = (word_r == hi_r[PW-1:5]) ? hi_r[4:0] : 5'd31;
    mask = (32'hFFFF_FFFF << lo_b) & (32'hFFFF_FFFF >> (5'd31 - hi_b));
  end

  // lowest free page in the word
  always_comb begin
    first_b = 5'd0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (mem_rd_r[i]) first_b = 5'(i);
    end
  end

  // run search over eight pages per cycle
  always_comb begin
    sub_bits = mem_rd_r[sub_r*SUB_BITS +: SUB_BITS];
    run_v = run_r;
    hit_v = 1'b0;
    end_v = '0;
    for (int i = 0; i < SUB_BITS; i++) begin
      if (!hit_v) begin
        if (sub_bits[i]) begin
          run_v = run_v + 13'd1;
          if (run_v == len_r) begin
            hit_v = 1'b1;
            end_v = CW'({word_r, sub_r, 3'(i)});
          end
        end else begin
          run_v = 13'd0;
        end
      end
    end
    start_v = end_v - CW'(len_r) + CW'(1);
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    word_nxt      = word_r;
    sub_nxt       = sub_r;
    run_nxt       = run_r;
    len_nxt       = len_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    set_nxt       = set_r;
    res_start_nxt = res_start_r;
    res_found_nxt = res_found_r;
    res_err_nxt   = res_err_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_wd        = '0;
    page_c        = CW'(in_page_number);
    hi_c          = page_c + CW'(in_run_length) - CW'(1);

    case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        if (word_r == LAST_WORD) begin
          state_nxt = S_IDLE;
        end else begin
          word_nxt = word_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          res_start_nxt = '0;
          res_found_nxt = 1'b0;
          res_err_nxt   = 1'b0;
          len_nxt       = in_run_length;
          run_nxt       = '0;
          sub_nxt       = '0;
          word_nxt      = '0;
          state_nxt     = S_DONE;
          case (in_req_type)
            REQ_ALLOC_ONE: begin
              mode_nxt  = M_ONE;
              state_nxt = S_RD;
            end
            REQ_ALLOC_RUN: begin
              mode_nxt = M_RUN;
              if (in_run_length != 13'd0) state_nxt = S_RD;
            end
            REQ_FREE_ONE, REQ_MARK_USED: begin
              if (page_c < PAGE_COUNT) begin
                mode_nxt  = M_RANGE;
                set_nxt   = (in_req_type == REQ_FREE_ONE);
                lo_nxt    = page_c[PW-1:0];
                hi_nxt    = page_c[PW-1:0];
                word_nxt  = page_c[PW-1:5];
                state_nxt = S_RD;
              end else begin
                res_err_nxt = 1'b1;
              end
            end
            REQ_FREE_RUN: begin
              if (in_run_length != 13'd0) begin
                if (page_c >= PAGE_COUNT) begin
                  res_err_nxt = 1'b1;
                end else begin
                  mode_nxt  = M_RANGE;
                  set_nxt   = 1'b1;
                  lo_nxt    = page_c[PW-1:0];
                  word_nxt  = page_c[PW-1:5];
                  state_nxt = S_RD;
                  if (hi_c >= PAGE_COUNT) begin
                    res_err_nxt = 1'b1;
                    hi_nxt      = PW'(PAGE_COUNT - CW'(1));
                  end else begin
                    hi_nxt = hi_c[PW-1:0];
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        state_nxt = S_EX;
      end
      S_EX: begin
        case (mode_r)
          M_ONE: begin
            if (mem_rd_r != '0) begin
              mem_we        = 1'b1;
              mem_wd        = mem_rd_r & ~(32'd1 << first_b);
              res_start_nxt = 12'(CW'({word_r, first_b}));
              res_found_nxt = 1'b1;
              state_nxt     = S_DONE;
            end else if (word_r == LAST_WORD) begin
              state_nxt = S_DONE;
            end else begin
              word_nxt  = word_r + AW'(1);
              state_nxt = S_RD;
            end
          end
          M_RUN: begin
            run_nxt = run_v;
            if (hit_v) begin
              // take the run: clear pass from its first word
              mode_nxt      = M_RANGE;
              set_nxt       = 1'b0;
              lo_nxt        = start_v[PW-1:0];
              hi_nxt        = end_v[PW-1:0];
              word_nxt      = start_v[PW-1:5];
              res_start_nxt = start_v[11:0];
              res_found_nxt = 1'b1;
              state_nxt     = S_RD;
            end else if (sub_r != 2'd3) begin
              sub_nxt = sub_r + 2'd1;
            end else if (word_r == LAST_WORD) begin
              state_nxt = S_DONE;
            end else begin
              sub_nxt   = '0;
              word_nxt  = word_r + AW'(1);
              state_nxt = S_RD;
            end
          end
          M_RANGE: begin
            mem_we = 1'b1;
            mem_wd = set_r ? (mem_rd_r | mask) : (mem_rd_r & ~mask);
            if (word_r == hi_r[PW-1:5]) begin
              state_nxt = S_DONE;
            end else begin
              word_nxt  = word_r + AW'(1);
              state_nxt = S_RD;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      word_r      <= '0;
      out_valid_r <= 1'b0;
      mode_r      <= M_ONE;
      sub_r       <= '0;
      run_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      word_r      <= word_nxt;
      out_valid_r <= out_valid_nxt;
      mode_r      <= mode_nxt;
      sub_r       <= sub_nxt;
      run_r       <= run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r       <= len_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    set_r       <= set_nxt;
    res_start_r <= res_start_nxt;
    res_found_r <= res_found_nxt;
    res_err_r   <= res_err_nxt;
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_start_r <= res_start_r;
      out_found_r <= res_found_r;
      out_err_r   <= res_err_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_start_page  = out_start_r;
  assign out_found       = out_found_r;
  assign out_range_error = out_err_r;

`ifndef SYNTHESIS
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_EX || state_r == S_CLR))
    else $error("map write outside execute or clear");
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("accepted beat did not start work");
  a_found_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_found && out_range_error))
    else $error("result both found and range error");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && out_stall) |=> (state_r == S_DONE))
    else $error("result dropped while output full");
`endif

endmodule
